FILE: src/bdwc_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and helpers of the block damage window classifier.
package bdwc_pkg;

    localparam int MAX_WIDTH_DEF = 32;

    localparam int Q_W        = 16;
    localparam int ROW_W      = 12;
    localparam int COL_OUT_W  = 5;
    localparam int GRADE_W    = 2;
    localparam int IDX_W      = 6;
    localparam int CLS_W      = 2;
    localparam int MW_W       = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [MW_W-1:0]  RST_MAP_WIDTH    = 6'd32;
    localparam logic [ROW_W-1:0] RST_MAP_HEIGHT   = 12'd32;
    localparam logic [Q_W-1:0]   RST_LOW_LIMIT    = 16'd2540;
    localparam logic [Q_W-1:0]   RST_DMG_LIMIT    = 16'd1802;
    localparam logic [IDX_W-1:0] RST_BORDER_LIMIT = 6'd20;
    localparam logic [IDX_W-1:0] RST_INNER_LIMIT  = 6'd35;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAP_WIDTH    = 3'd0,
        REG_MAP_HEIGHT   = 3'd1,
        REG_LOW_LIMIT    = 3'd2,
        REG_DMG_LIMIT    = 3'd3,
        REG_BORDER_LIMIT = 3'd4,
        REG_INNER_LIMIT  = 3'd5
    } t_reg_idx;

    typedef enum logic [GRADE_W-1:0] {
        GRADE_OK  = 2'd0,
        GRADE_LOW = 2'd1,
        GRADE_DMG = 2'd2
    } t_grade;

    typedef enum logic [CLS_W-1:0] {
        AREA_NONE   = 2'd0,
        AREA_BORDER = 2'd1,
        AREA_INNER  = 2'd2
    } t_area;

    typedef struct packed {
        logic [Q_W-1:0] quality;
        logic           is_background;
    } t_in;

    typedef struct packed {
        logic [ROW_W-1:0]     out_row;
        logic [COL_OUT_W-1:0] out_col;
        logic [GRADE_W-1:0]   category;
        logic [IDX_W-1:0]     damage_index;
        logic [CLS_W-1:0]     area_class;
        logic                 last;
    } t_out;

    // Results pending for one accepted item.
    typedef struct packed {
        logic left_res;   // window centred one column back
        logic edge_res;   // row end, window centred on this column
        logic flush;      // frame end, whole last row follows
    } t_job_ctl;

    // Score of one window column of three grades: 5 per damaged, 3 per low.
    function automatic logic [3:0] col_score(input logic [3*GRADE_W-1:0] col);
        logic [3:0] s;
        s = 4'd0;
        for (int k = 0; k < 3; k++) begin
            case (t_grade'(col[GRADE_W*k +: GRADE_W]))
                GRADE_DMG: s = s + 4'd5;
                GRADE_LOW: s = s + 4'd3;
                default:   s = s;
            endcase
        end
        return s;
    endfunction

endpackage

FILE: src/block_damage_window_classifier_unit.sv
`timescale 1ns / 1ps
// Top level of the block damage window classifier.
//
// Grades a raster stream of block qualities and classifies each block from
// the damage index of its 3x3 window. One item is taken per cycle; a result
// for block (r-1, c-1) leaves through an output register while the next
// item enters. The input is held until the last result of the current
// item moves out, so items with several results and output stalls hold
// it longer. An item that ends a row from the second row on adds the
// result for the row's last column. The final item of a frame also
// flushes the last row, one result per column, while a sequencer walks
// the row store through its read port and its tap on cell 0. The row
// store is a row of MAX_WIDTH column cells, cleared by reset.
module block_damage_window_classifier_unit
    import bdwc_pkg::*;
#(
    parameter  int MAX_WIDTH = MAX_WIDTH_DEF,
    localparam int XW        = $clog2(MAX_WIDTH),
    localparam int CW        = $clog2(MAX_WIDTH + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in                   i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out                  o_out_data
);

    localparam int GW = 3 * GRADE_W;
    localparam int SW = 2 * GRADE_W;

    logic [MW_W-1:0]  r_map_width;
    logic [ROW_W-1:0] r_map_height;
    logic [Q_W-1:0]   r_low_limit;
    logic [Q_W-1:0]   r_dmg_limit;
    logic [IDX_W-1:0] r_border_limit;
    logic [IDX_W-1:0] r_inner_limit;

    logic [XW-1:0]    r_col;
    logic [ROW_W-1:0] r_row;
    logic [GW-1:0]    r_win0, r_win1;

    logic [CW-1:0]      w_eff;
    logic [ROW_W-1:0]   h_eff;
    logic [CW-1:0]      c_inc;
    logic [ROW_W:0]     r_inc;
    logic               end_row, frame_end, accept;
    t_grade             cur;
    logic [GRADE_W-1:0] prevm, oldm;
    logic [GW-1:0]      nw0, nw1, nw2;
    logic [XW-1:0]      rd_addr, flush_addr;
    logic               flush_rd;
    logic [SW-1:0]      rd_data, cell0;
    t_job_ctl           ctl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_width    <= RST_MAP_WIDTH;
            r_map_height   <= RST_MAP_HEIGHT;
            r_low_limit    <= RST_LOW_LIMIT;
            r_dmg_limit    <= RST_DMG_LIMIT;
            r_border_limit <= RST_BORDER_LIMIT;
            r_inner_limit  <= RST_INNER_LIMIT;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_addr))
                REG_MAP_WIDTH:    r_map_width    <= i_cfg_wdata[MW_W-1:0];
                REG_MAP_HEIGHT:   r_map_height   <= i_cfg_wdata[ROW_W-1:0];
                REG_LOW_LIMIT:    r_low_limit    <= i_cfg_wdata[Q_W-1:0];
                REG_DMG_LIMIT:    r_dmg_limit    <= i_cfg_wdata[Q_W-1:0];
                REG_BORDER_LIMIT: r_border_limit <= i_cfg_wdata[IDX_W-1:0];
                REG_INNER_LIMIT:  r_inner_limit  <= i_cfg_wdata[IDX_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_map_width == '0) begin
            w_eff = CW'(1);
        end else if (32'(r_map_width) > MAX_WIDTH) begin
            w_eff = CW'(MAX_WIDTH);
        end else begin
            w_eff = CW'(r_map_width);
        end
        h_eff = (r_map_height == '0) ? 12'd1 : r_map_height;
    end

    assign accept    = i_in_valid && o_in_ready;
    assign c_inc     = CW'(r_col) + CW'(1);
    assign r_inc     = {1'b0, r_row} + 13'd1;
    // A column count at or past the width ends the row at once.
    assign end_row   = c_inc >= w_eff;
    assign frame_end = end_row && (r_inc >= {1'b0, h_eff});

    always_comb begin
        if (i_in_data.is_background) begin
            cur = GRADE_OK;
        end else if (i_in_data.quality < r_dmg_limit) begin
            cur = GRADE_DMG;
        end else if (i_in_data.quality < r_low_limit) begin
            cur = GRADE_LOW;
        end else begin
            cur = GRADE_OK;
        end
    end

    assign rd_addr = flush_rd ? flush_addr : r_col;

    // Rows above the map read as ok.
    assign prevm = (r_row != '0) ? rd_data[SW-1:GRADE_W] : GRADE_OK;
    assign oldm  = (r_row[ROW_W-1:1] != '0) ? rd_data[GRADE_W-1:0] : GRADE_OK;

    assign nw0 = {cur, prevm, oldm};
    assign nw1 = (r_col == '0) ? '0 : r_win0;
    assign nw2 = (r_col == '0) ? '0 : r_win1;

    assign ctl.left_res = (r_row != '0) && (r_col != '0);
    assign ctl.edge_res = (r_row != '0) && end_row;
    assign ctl.flush    = frame_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_win0 <= '0;
            r_win1 <= '0;
        end else if (accept) begin
            r_win0 <= nw0;
            r_win1 <= nw1;
            if (end_row) begin
                r_col <= '0;
                r_row <= frame_end ? '0 : r_inc[ROW_W-1:0];
            end else begin
                r_col <= XW'(c_inc);
            end
        end
    end

    bdwc_row_store #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_row_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_we        (accept),
        .i_wr_addr   (r_col),
        .i_cur       (cur),
        .i_keep_prev (r_row != '0),
        .i_rd_addr   (rd_addr),
        .o_rd_data   (rd_data),
        .o_cell0     (cell0)
    );

    bdwc_emitter #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_emitter (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (accept),
        .i_ctl          (ctl),
        .i_row          (r_row),
        .i_col          (r_col),
        .i_win2         (nw2),
        .i_win1         (nw1),
        .i_win0         (nw0),
        .i_width        (w_eff),
        .i_border_limit (r_border_limit),
        .i_inner_limit  (r_inner_limit),
        .i_rd           (rd_data),
        .i_cell0        (cell0),
        .o_flush_addr   (flush_addr),
        .o_flush_rd     (flush_rd),
        .o_in_ready     (o_in_ready),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_data     (o_out_data)
    );

endmodule

FILE: src/bdwc_cell.sv
`timescale 1ns / 1ps
// One column cell of the line store: grades of the two rows above the current one.
module bdwc_cell
    import bdwc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_we,
    input  logic [GRADE_W-1:0] i_cur,
    input  logic               i_keep_prev,
    output logic [2*GRADE_W-1:0] o_q
);

    logic [GRADE_W-1:0] r_older;
    logic [GRADE_W-1:0] r_prev;

    // On write the previous-row grade ages into the older row; in the first
    // row of a frame there is no row above, so it ages as ok.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_older <= GRADE_OK;
            r_prev  <= GRADE_OK;
        end else if (i_we) begin
            r_older <= i_keep_prev ? r_prev : GRADE_OK;
            r_prev  <= i_cur;
        end
    end

    assign o_q = {r_prev, r_older};

endmodule

FILE: src/bdwc_row_store.sv
`timescale 1ns / 1ps
// Row of column cells with one write port, one read port and a fixed tap on cell 0.
module bdwc_row_store
    import bdwc_pkg::*;
#(
    parameter  int MAX_WIDTH = MAX_WIDTH_DEF,
    localparam int XW        = $clog2(MAX_WIDTH)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_we,
    input  logic [XW-1:0]        i_wr_addr,
    input  logic [GRADE_W-1:0]   i_cur,
    input  logic                 i_keep_prev,
    input  logic [XW-1:0]        i_rd_addr,
    output logic [2*GRADE_W-1:0] o_rd_data,
    output logic [2*GRADE_W-1:0] o_cell0
);

    logic [2*GRADE_W-1:0] cell_q [MAX_WIDTH];

    for (genvar i = 0; i < MAX_WIDTH; i++) begin : g_cell
        bdwc_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_we        (i_we && (i_wr_addr == XW'(i))),
            .i_cur       (i_cur),
            .i_keep_prev (i_keep_prev),
            .o_q         (cell_q[i])
        );
    end

    assign o_rd_data = (32'(i_rd_addr) < MAX_WIDTH) ? cell_q[i_rd_addr] : '0;
    assign o_cell0   = cell_q[0];

endmodule

FILE: src/bdwc_emitter.sv
`timescale 1ns / 1ps
// Result sequencer: pending results of one item, row flush walk and output register.
module bdwc_emitter
    import bdwc_pkg::*;
#(
    parameter  int MAX_WIDTH = MAX_WIDTH_DEF,
    localparam int XW        = $clog2(MAX_WIDTH),
    localparam int CW        = $clog2(MAX_WIDTH + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  t_job_ctl             i_ctl,
    input  logic [ROW_W-1:0]     i_row,
    input  logic [XW-1:0]        i_col,
    input  logic [3*GRADE_W-1:0] i_win2,
    input  logic [3*GRADE_W-1:0] i_win1,
    input  logic [3*GRADE_W-1:0] i_win0,
    input  logic [CW-1:0]        i_width,
    input  logic [IDX_W-1:0]     i_border_limit,
    input  logic [IDX_W-1:0]     i_inner_limit,
    input  logic [2*GRADE_W-1:0] i_rd,
    input  logic [2*GRADE_W-1:0] i_cell0,
    output logic [XW-1:0]        o_flush_addr,
    output logic                 o_flush_rd,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out                 o_out_data
);

    localparam int GW = 3 * GRADE_W;
    localparam int SW = 2 * GRADE_W;

    logic                 r_ja, r_jb, r_jf;
    logic [ROW_W-1:0]     r_row;
    logic [XW-1:0]        r_col;
    logic [GW-1:0]        r_w2, r_w1, r_w0;
    logic [XW-1:0]        r_fx;
    logic [SW-1:0]        r_fl, r_fm;
    logic                 r_o_valid;
    t_out                 r_o;

    logic                 sel_a, sel_b, sel_f, pending;
    logic                 fl_last, pick_last, move;
    logic [GW-1:0]        res_l, res_m, res_r;
    logic [ROW_W-1:0]     res_row;
    logic [COL_OUT_W-1:0] res_col;
    logic [IDX_W-1:0]     res_idx;
    t_area                res_cls;
    t_out                 res_data;

    assign sel_a   = r_ja;
    assign sel_b   = !r_ja && r_jb;
    assign sel_f   = !r_ja && !r_jb && r_jf;
    assign pending = r_ja || r_jb || r_jf;
    assign fl_last = (CW'(r_fx) + CW'(1)) >= i_width;

    always_comb begin
        if (sel_a) begin
            pick_last = !(r_jb || r_jf);
        end else if (sel_b) begin
            pick_last = !r_jf;
        end else begin
            pick_last = fl_last;
        end
    end

    assign move       = pending && (!r_o_valid || i_out_ready);
    assign o_in_ready = !pending || (move && pick_last);

    // Flush walk reads the right-hand column one ahead of the walk position.
    assign o_flush_addr = XW'(r_fx + 1'b1);
    assign o_flush_rd   = sel_f && !fl_last;

    always_comb begin
        if (sel_a) begin
            res_l   = r_w2;
            res_m   = r_w1;
            res_r   = r_w0;
            res_row = r_row - 12'd1;
            res_col = COL_OUT_W'(r_col - XW'(1));
        end else if (sel_b) begin
            res_l   = r_w1;
            res_m   = r_w0;
            res_r   = '0;
            res_row = r_row - 12'd1;
            res_col = COL_OUT_W'(r_col);
        end else begin
            res_l   = (r_fx == '0) ? '0 : {2'b00, r_fl};
            res_m   = (r_fx == '0) ? {2'b00, i_cell0} : {2'b00, r_fm};
            res_r   = fl_last ? '0 : {2'b00, i_rd};
            res_row = r_row;
            res_col = COL_OUT_W'(r_fx);
        end
    end

    always_comb begin
        res_idx = IDX_W'(col_score(res_l)) + IDX_W'(col_score(res_m))
                + IDX_W'(col_score(res_r));
        if (res_idx > i_inner_limit) begin
            res_cls = AREA_INNER;
        end else if (res_idx > i_border_limit) begin
            res_cls = AREA_BORDER;
        end else begin
            res_cls = AREA_NONE;
        end
        res_data.out_row      = res_row;
        res_data.out_col      = res_col;
        res_data.category     = res_m[2*GRADE_W-1:GRADE_W];
        res_data.damage_index = res_idx;
        res_data.area_class   = res_cls;
        res_data.last         = pick_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ja      <= 1'b0;
            r_jb      <= 1'b0;
            r_jf      <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (move) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
            if (i_load) begin
                r_ja <= i_ctl.left_res;
                r_jb <= i_ctl.edge_res;
                r_jf <= i_ctl.flush;
            end else if (move) begin
                if (sel_a) begin
                    r_ja <= 1'b0;
                end else if (sel_b) begin
                    r_jb <= 1'b0;
                end else if (fl_last) begin
                    r_jf <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_o <= res_data;
        end
        if (i_load) begin
            r_row <= i_row;
            r_col <= i_col;
            r_w2  <= i_win2;
            r_w1  <= i_win1;
            r_w0  <= i_win0;
            r_fx  <= '0;
        end else if (move && sel_f) begin
            r_fx <= XW'(r_fx + 1'b1);
            r_fl <= res_m[SW-1:0];
            r_fm <= res_r[SW-1:0];
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_data  = r_o;

    a_ready_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_ready && !i_load) |=> !(r_ja || r_jb || r_jf))
        else $error("job not empty after input was offered ready");

    a_job_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pending && !o_in_ready) |=> (r_ja || r_jb || r_jf))
        else $error("pending results dropped before delivery");

    a_flush_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_load && i_ctl.flush && (i_row != '0)) |-> i_ctl.edge_res)
        else $error("frame end below first row without row end result");

endmodule

FILE: tb/block_damage_window_classifier_unit_test.sv
`timescale 1ns / 1ps
// Self-checking testbench of the block damage window classifier, predictor based.
module block_damage_window_classifier_unit_test;
    import bdwc_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int MAX_W        = MAX_WIDTH_DEF;
    localparam int DRAIN_CYCLES = MAX_W + 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int N_PHASES     = 12;
    localparam int DIR_LEN      = 40;

    typedef enum logic {DO_BLK, DO_REG} t_step_kind;

    // One row of the directed table: a register write or one block.
    // For blocks with typed set, want is the result read straight off the spec.
    typedef struct packed {
        t_step_kind  kind;
        t_reg_idx    sel;
        logic [15:0] value;
        logic        bg;
        logic        typed;
        t_out        want;
    } t_step;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  i_in_valid  = 1'b0;
    t_in                   i_in_data   = '0;
    logic                  i_out_ready = 1'b0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    t_out                  o_out_data;

    block_damage_window_classifier_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Predictor copy of the configuration and the window state.
    logic [5:0]  cfg_width   = RST_MAP_WIDTH;
    logic [11:0] cfg_height  = RST_MAP_HEIGHT;
    logic [15:0] cfg_low_lim = RST_LOW_LIMIT;
    logic [15:0] cfg_dmg_lim = RST_DMG_LIMIT;
    logic [5:0]  cfg_border  = RST_BORDER_LIMIT;
    logic [5:0]  cfg_inner   = RST_INNER_LIMIT;

    t_grade      older_row [MAX_W];
    t_grade      prev_row  [MAX_W];
    logic [5:0]  win_cols  [3];     // {bottom, middle, top} grades per column
    int unsigned col_cnt = 0;
    int unsigned row_cnt = 0;

    t_out block_outcome   [$];      // results caused by the block just predicted
    t_out awaited_classes [$];      // results still owed by the DUT, oldest first

    int mismatch_cnt   = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    t_step dir_steps [DIR_LEN] = '{
        // single-block frames: every block is a whole map and gives one result
        '{DO_REG, REG_MAP_HEIGHT,   1,     0, 0, '0},
        '{DO_REG, REG_MAP_WIDTH,    1,     0, 0, '0},
        '{DO_BLK, REG_MAP_WIDTH,    0,     0, 1, '{'0, '0, GRADE_DMG, 5, AREA_NONE, 1}},
        '{DO_BLK, REG_MAP_WIDTH,    1801,  0, 1, '{'0, '0, GRADE_DMG, 5, AREA_NONE, 1}},
        '{DO_BLK, REG_MAP_WIDTH,    1802,  0, 1, '{'0, '0, GRADE_LOW, 3, AREA_NONE, 1}},
        '{DO_BLK, REG_MAP_WIDTH,    2539,  0, 1, '{'0, '0, GRADE_LOW, 3, AREA_NONE, 1}},
        '{DO_BLK, REG_MAP_WIDTH,    2540,  0, 1, '{'0, '0, GRADE_OK,  0, AREA_NONE, 1}},
        '{DO_BLK, REG_MAP_WIDTH,    65535, 0, 1, '{'0, '0, GRADE_OK,  0, AREA_NONE, 1}},
        '{DO_BLK, REG_MAP_WIDTH,    0,     1, 1, '{'0, '0, GRADE_OK,  0, AREA_NONE, 1}},
        '{DO_REG, REG_BORDER_LIMIT, 0,     0, 0, '0},
        '{DO_REG, REG_INNER_LIMIT,  4,     0, 0, '0},
        '{DO_BLK, REG_MAP_WIDTH,    0,     0, 1, '{'0, '0, GRADE_DMG, 5, AREA_INNER, 1}},
        '{DO_BLK, REG_MAP_WIDTH,    2000,  0, 1, '{'0, '0, GRADE_LOW, 3, AREA_BORDER, 1}},
        '{DO_BLK, REG_MAP_WIDTH,    65535, 1, 1, '{'0, '0, GRADE_OK,  0, AREA_NONE, 1}},
        // inner limit below border limit: inner wins
        '{DO_REG, REG_BORDER_LIMIT, 45,    0, 0, '0},
        '{DO_BLK, REG_MAP_WIDTH,    0,     0, 1, '{'0, '0, GRADE_DMG, 5, AREA_INNER, 1}},
        '{DO_BLK, REG_MAP_WIDTH,    2000,  0, 1, '{'0, '0, GRADE_LOW, 3, AREA_NONE, 1}},
        // damaged limit above low limit: damaged wins
        '{DO_REG, REG_LOW_LIMIT,    0,     0, 0, '0},
        '{DO_REG, REG_DMG_LIMIT,    65535, 0, 0, '0},
        '{DO_BLK, REG_MAP_WIDTH,    65534, 0, 1, '{'0, '0, GRADE_DMG, 5, AREA_INNER, 1}},
        '{DO_BLK, REG_MAP_WIDTH,    65535, 0, 1, '{'0, '0, GRADE_OK,  0, AREA_NONE, 1}},
        // zero width and zero height both act as one
        '{DO_REG, REG_MAP_WIDTH,    0,     0, 0, '0},
        '{DO_BLK, REG_MAP_WIDTH,    30000, 0, 1, '{'0, '0, GRADE_DMG, 5, AREA_INNER, 1}},
        '{DO_REG, REG_MAP_HEIGHT,   0,     0, 0, '0},
        '{DO_BLK, REG_MAP_WIDTH,    65535, 0, 1, '{'0, '0, GRADE_OK,  0, AREA_NONE, 1}},
        // 3x3 map, heavily damaged, checked by the predictor
        '{DO_REG, REG_LOW_LIMIT,    2540,  0, 0, '0},
        '{DO_REG, REG_DMG_LIMIT,    1802,  0, 0, '0},
        '{DO_REG, REG_BORDER_LIMIT, 20,    0, 0, '0},
        '{DO_REG, REG_INNER_LIMIT,  35,    0, 0, '0},
        '{DO_REG, REG_MAP_WIDTH,    3,     0, 0, '0},
        '{DO_REG, REG_MAP_HEIGHT,   3,     0, 0, '0},
        '{DO_BLK, REG_MAP_WIDTH,    0,     0, 0, '0},
        '{DO_BLK, REG_MAP_WIDTH,    0,     0, 0, '0},
        '{DO_BLK, REG_MAP_WIDTH,    2000,  0, 0, '0},
        '{DO_BLK, REG_MAP_WIDTH,    0,     0, 0, '0},
        '{DO_BLK, REG_MAP_WIDTH,    0,     1, 0, '0},
        '{DO_BLK, REG_MAP_WIDTH,    0,     0, 0, '0},
        '{DO_BLK, REG_MAP_WIDTH,    2000,  0, 0, '0},
        '{DO_BLK, REG_MAP_WIDTH,    65535, 0, 0, '0},
        '{DO_BLK, REG_MAP_WIDTH,    0,     0, 0, '0}
    };

    function automatic int unsigned column_damage(input logic [5:0] col);
        int unsigned sum;
        sum = 0;
        for (int k = 0; k < 3; k++) begin
            if (col[2*k +: 2] == GRADE_DMG) sum += 5;
            else if (col[2*k +: 2] == GRADE_LOW) sum += 3;
        end
        return sum;
    endfunction

    function automatic t_out window_result(input int unsigned row, input int unsigned col,
                                           input logic [5:0] lft, input logic [5:0] mid,
                                           input logic [5:0] rgt);
        t_out        res;
        int unsigned idx;
        idx = column_damage(lft) + column_damage(mid) + column_damage(rgt);
        res.out_row      = row[ROW_W-1:0];
        res.out_col      = col[COL_OUT_W-1:0];
        res.category     = mid[3:2];
        res.damage_index = idx[IDX_W-1:0];
        res.area_class   = (idx > cfg_inner) ? AREA_INNER :
                           ((idx > cfg_border) ? AREA_BORDER : AREA_NONE);
        res.last         = 1'b0;
        return res;
    endfunction

    // Grades one block, slides the window and collects the results it releases.
    task automatic classify_block(input t_in blk);
        int unsigned w, h, c, r, x;
        t_grade      cur, prevm, oldm;
        logic [5:0]  lft, rgt;
        logic        end_row;
        block_outcome.delete();
        w = (cfg_width == 0) ? 1 : ((cfg_width > MAX_W) ? MAX_W : cfg_width);
        h = (cfg_height == 0) ? 1 : cfg_height;
        c = (col_cnt >= MAX_W) ? MAX_W - 1 : col_cnt;
        r = row_cnt;
        if (blk.is_background) cur = GRADE_OK;
        else if (blk.quality < cfg_dmg_lim) cur = GRADE_DMG;
        else if (blk.quality < cfg_low_lim) cur = GRADE_LOW;
        else cur = GRADE_OK;
        prevm = (r >= 1) ? prev_row[c] : GRADE_OK;
        oldm  = (r >= 2) ? older_row[c] : GRADE_OK;
        win_cols[2] = (c == 0) ? 6'd0 : win_cols[1];
        win_cols[1] = (c == 0) ? 6'd0 : win_cols[0];
        win_cols[0] = {cur, prevm, oldm};
        end_row = (c + 1 >= w);
        if (r >= 1 && c >= 1)
            block_outcome.insert(block_outcome.size(),
                                 window_result(r - 1, c - 1,
                                               win_cols[2], win_cols[1], win_cols[0]));
        if (r >= 1 && end_row)
            block_outcome.insert(block_outcome.size(),
                                 window_result(r - 1, c, win_cols[1], win_cols[0], 6'd0));
        older_row[c] = prevm;
        prev_row[c]  = cur;
        if (end_row) begin
            col_cnt = 0;
            if (r + 1 >= h) begin
                // frame end: the last row is flushed straight from the row stores
                for (x = 0; x < w; x++) begin
                    lft = (x >= 1) ? {2'b00, prev_row[x-1], older_row[x-1]} : 6'd0;
                    rgt = (x + 1 < w) ? {2'b00, prev_row[x+1], older_row[x+1]} : 6'd0;
                    block_outcome.insert(block_outcome.size(),
                                         window_result(r, x, lft,
                                                       {2'b00, prev_row[x], older_row[x]},
                                                       rgt));
                end
                row_cnt = 0;
            end else begin
                row_cnt = (r + 1) & 12'hFFF;
            end
        end else begin
            col_cnt = c + 1;
        end
        if (block_outcome.size() > 0) block_outcome[block_outcome.size()-1].last = 1'b1;
    endtask

    task automatic write_reg(input t_reg_idx sel, input logic [15:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= sel;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (sel)
            REG_MAP_WIDTH:    cfg_width   = val[5:0];
            REG_MAP_HEIGHT:   cfg_height  = val[11:0];
            REG_LOW_LIMIT:    cfg_low_lim = val;
            REG_DMG_LIMIT:    cfg_dmg_lim = val;
            REG_BORDER_LIMIT: cfg_border  = val[5:0];
            REG_INNER_LIMIT:  cfg_inner   = val[5:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Block must be idle before a register write: results drained, then slack
    // for an item still in flight that owes nothing.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (awaited_classes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_block(input t_in blk);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= blk;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    function automatic t_in draw_block();
        t_in         blk;
        logic [15:0] jitter;
        jitter = 16'($urandom_range(63)) - 16'd32;
        case ($urandom_range(5))
            0:       blk.quality = 16'($urandom_range(16'hFFFF));
            1:       blk.quality = $urandom_range(1) ? 16'hFFFF : 16'h0000;
            2, 3:    blk.quality = cfg_dmg_lim + jitter;
            default: blk.quality = cfg_low_lim + jitter;
        endcase
        blk.is_background = ($urandom_range(4) == 0);
        return blk;
    endfunction

    // New geometry and limits for a random phase; the frame in progress is
    // usually cut short, which exercises the mid-frame geometry change.
    task automatic retune(input int ph);
        logic [15:0] w, h, lo, dm, bo, inr, tmp;
        case ($urandom_range(7))
            0:       w = 0;
            1:       w = 16'($urandom_range(33, 63));
            2:       w = 32;
            3:       w = 1;
            default: w = 16'($urandom_range(2, 7));
        endcase
        case ($urandom_range(7))
            0:       h = 0;
            1:       h = 16'($urandom_range(1000, 4095));
            2:       h = 1;
            default: h = 16'($urandom_range(2, 5));
        endcase
        if (ph == 1) w = 63;
        if (ph == 2) begin
            w = 32;
            h = 2;
        end
        if (ph == 3) h = 4095;
        case ($urandom_range(5))
            0: begin
                lo = 16'($urandom_range(16'hFFFF));
                dm = 16'($urandom_range(16'hFFFF));
            end
            1: begin
                lo = 16'h0000;
                dm = 16'hFFFF;
            end
            2: begin
                lo = 16'hFFFF;
                dm = 16'h0000;
            end
            default: begin
                lo = 16'($urandom_range(2000, 3000));
                dm = 16'($urandom_range(1500, 2000));
            end
        endcase
        bo  = 16'($urandom_range(45));
        inr = 16'($urandom_range(45));
        if (bo > inr && $urandom_range(3) != 0) begin
            tmp = bo;
            bo  = inr;
            inr = tmp;
        end
        if ($urandom_range(9) == 0) bo = 16'($urandom_range(46, 63));
        if ($urandom_range(9) == 0) inr = 16'($urandom_range(46, 63));
        write_reg(REG_MAP_WIDTH, w);
        write_reg(REG_MAP_HEIGHT, h);
        write_reg(REG_LOW_LIMIT, lo);
        write_reg(REG_DMG_LIMIT, dm);
        write_reg(REG_BORDER_LIMIT, bo);
        write_reg(REG_INNER_LIMIT, inr);
    endtask

    task automatic check_result(input t_out got);
        t_out want;
        if (awaited_classes.size() == 0) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
                $display("unexpected result: row %0d col %0d cat %0d idx %0d area %0d last %0d",
                         got.out_row, got.out_col, got.category, got.damage_index,
                         got.area_class, got.last);
        end else begin
            want = awaited_classes.pop_front();
            if (got.out_row !== want.out_row || got.out_col !== want.out_col ||
                got.category !== want.category || got.damage_index !== want.damage_index ||
                got.area_class !== want.area_class || got.last !== want.last) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10) begin
                    $display("mismatch: expected row %0d col %0d cat %0d idx %0d area %0d last %0d",
                             want.out_row, want.out_col, want.category, want.damage_index,
                             want.area_class, want.last);
                    $display("          actual   row %0d col %0d cat %0d idx %0d area %0d last %0d",
                             got.out_row, got.out_col, got.category, got.damage_index,
                             got.area_class, got.last);
                end
            end
        end
    endtask

    // Result side: check on every transfer, then pick the next ready level.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) check_result(o_out_data);
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin
        int cyc;
        for (cyc = 0; cyc < CYCLE_LIMIT; cyc++) @(posedge i_clk);
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        t_in   blk;
        t_step st;
        int    n_blocks;
        foreach (prev_row[i]) begin
            prev_row[i]  = GRADE_OK;
            older_row[i] = GRADE_OK;
        end
        foreach (win_cols[i]) win_cols[i] = 6'd0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_steps[i]) begin
            st = dir_steps[i];
            if (st.kind == DO_REG) begin
                settle();
                write_reg(st.sel, st.value);
            end else begin
                blk.quality       = st.value;
                blk.is_background = st.bg;
                classify_block(blk);
                if (st.typed) awaited_classes.insert(awaited_classes.size(), st.want);
                else foreach (block_outcome[k])
                    awaited_classes.insert(awaited_classes.size(), block_outcome[k]);
                send_block(blk);
            end
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            settle();
            retune(ph);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
                default: begin send_idle_pct = 17; recv_stall_pct = 17; end
            endcase
            n_blocks = (ph == 2) ? 64 : $urandom_range(20, 45);
            repeat (n_blocks) begin
                blk = draw_block();
                classify_block(blk);
                foreach (block_outcome[k])
                    awaited_classes.insert(awaited_classes.size(), block_outcome[k]);
                send_block(blk);
            end
        end

        settle();
        if (mismatch_cnt == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
src/bdwc_pkg.sv
src/bdwc_cell.sv
src/bdwc_row_store.sv
src/bdwc_emitter.sv
src/block_damage_window_classifier_unit.sv
tb/block_damage_window_classifier_unit_test.sv
